[design/ssw_pkg.sv]
// shared types, constants and crc functions for the sensor safety word checker
// no dependencies
`default_nettype none

package ssw_pkg;

  localparam int WORD_W   = 16;
  localparam int CRC_W    = 8;
  localparam int MASK_W   = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_COMMAND = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_SAFETY  = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_SYSTEM    = 3'd1,
    ST_INTERFACE = 3'd2,
    ST_ANGLE     = 3'd3,
    ST_CRC       = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLYNOMIAL = 3'd0,
    REG_SEED       = 3'd1,
    REG_SYSTEM     = 3'd2,
    REG_INTERFACE  = 3'd3,
    REG_ANGLE      = 3'd4
  } reg_index_t;

  localparam logic [CRC_W-1:0]  POLY_RESET      = 8'h1D;
  localparam logic [CRC_W-1:0]  SEED_RESET      = 8'hFF;
  localparam logic [MASK_W-1:0] SYSTEM_RESET    = 16'h4000;
  localparam logic [MASK_W-1:0] INTERFACE_RESET = 16'h2000;
  localparam logic [MASK_W-1:0] ANGLE_RESET     = 16'h1000;
  localparam logic [CRC_W-1:0]  CRC_TOP         = 8'h80;

  // one byte msb first through the crc register
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] acc,
                                                 input logic [CRC_W-1:0] data,
                                                 input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] r;
    r = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((r & CRC_TOP) != '0) begin
        r = {r[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0] acc,
                                                 input logic [WORD_W-1:0] w,
                                                 input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] hi;
    hi = crc_byte(acc, w[15:8], poly);
    return crc_byte(hi, w[7:0], poly);
  endfunction

endpackage

`default_nettype wire

[design/sensor_safety_word_checker.sv]
// sensor safety word checker: frames of 16-bit link words closed by a crc-8 safety word
// depends on ssw_pkg
//
// One word beat is taken every cycle while word_stall is low. A word is held in the input
// register, where the crc update and status check are worked out combinationally; the result
// load happens when the word advances, so a safety word's result is registered in the result
// register. The two-byte crc update feeds the accumulator back combinationally. The
// output register lets the next words enter while a result waits to be taken;
// word_stall rises only when a safety word in the input register finds a stalled
// result still waiting. Configuration writes take effect at the next clock edge.
`default_nettype none

module sensor_safety_word_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [ssw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          word_valid,
  output logic                               word_stall,
  input  wire logic [ssw_pkg::KIND_W-1:0]     command,
  input  wire logic [ssw_pkg::WORD_W-1:0]     word_value,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [ssw_pkg::STATUS_W-1:0]        status,
  output logic [ssw_pkg::WORD_W-1:0]          data_word
);
  import ssw_pkg::*;

  logic [CRC_W-1:0]  poly;
  logic [CRC_W-1:0]  seed;
  logic [MASK_W-1:0] system_mask;
  logic [MASK_W-1:0] interface_mask;
  logic [MASK_W-1:0] angle_mask;

  logic              held_valid;
  kind_t             held_kind;
  logic [WORD_W-1:0] held_word;

  logic [CRC_W-1:0]  crc_acc;
  logic [CRC_W-1:0]  crc_acc_next;
  logic [WORD_W-1:0] last_data;
  logic [WORD_W-1:0] last_data_next;

  status_t           status_next;
  logic              needs_out;
  logic              advance;
  logic              take_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poly           <= POLY_RESET;
      seed           <= SEED_RESET;
      system_mask    <= SYSTEM_RESET;
      interface_mask <= INTERFACE_RESET;
      angle_mask     <= ANGLE_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_POLYNOMIAL: poly           <= cfg_data[CRC_W-1:0];
        REG_SEED:       seed           <= cfg_data[CRC_W-1:0];
        REG_SYSTEM:     system_mask    <= cfg_data;
        REG_INTERFACE:  interface_mask <= cfg_data;
        REG_ANGLE:      angle_mask     <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign needs_out  = held_valid && (held_kind == KIND_SAFETY);
  assign advance    = held_valid && (!needs_out || !result_valid || !result_stall);
  assign word_stall = held_valid && !advance;
  assign take_word  = word_valid && !word_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take_word) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_word) begin
      held_kind <= kind_t'(command);
      held_word <= word_value;
    end
  end

  // crc and frame state update
  always_comb begin
    crc_acc_next   = crc_acc;
    last_data_next = last_data;
    case (held_kind)
      KIND_COMMAND: begin
        crc_acc_next   = crc_word(seed, held_word, poly);
        last_data_next = '0;
      end
      KIND_DATA: begin
        crc_acc_next   = crc_word(crc_acc, held_word, poly);
        last_data_next = held_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc   <= SEED_RESET;
      last_data <= '0;
    end else if (advance) begin
      crc_acc   <= crc_acc_next;
      last_data <= last_data_next;
    end
  end

  // safety word check in priority order
  always_comb begin
    if ((held_word & system_mask) == '0) begin
      status_next = ST_SYSTEM;
    end else if ((held_word & interface_mask) == '0) begin
      status_next = ST_INTERFACE;
    end else if ((held_word & angle_mask) == '0) begin
      status_next = ST_ANGLE;
    end else if (~crc_acc != held_word[CRC_W-1:0]) begin
      status_next = ST_CRC;
    end else begin
      status_next = ST_OK;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && needs_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && needs_out) begin
      status    <= status_next;
      data_word <= (status_next == ST_OK) ? last_data : '0;
    end
  end

endmodule

`default_nettype wire

[design/ssw_checker.sv]
// port-level assertions for the sensor safety word checker, bound to its top level
// depends on ssw_pkg and sensor_safety_word_checker
`default_nettype none

module ssw_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          word_valid,
  input wire logic                          word_stall,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire logic [ssw_pkg::STATUS_W-1:0]   status,
  input wire logic [ssw_pkg::WORD_W-1:0]     data_word
);
  import ssw_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat present after reset");

  // status code stays within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_OK || status == ST_SYSTEM || status == ST_INTERFACE ||
                      status == ST_ANGLE || status == ST_CRC))
    else $error("undefined status code");

  // any error forces the data word to zero
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> data_word == '0)
    else $error("data word not cleared on error");

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(status) && $stable(data_word)))
    else $error("stalled result beat changed");

  // a word beat is held back only behind a stalled result beat
  a_word_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (word_valid && word_stall) |-> (result_valid && result_stall))
    else $error("word beat stalled without a waiting result");

endmodule

bind sensor_safety_word_checker ssw_checker u_ssw_checker (
  .clk          (clk),
  .rst          (rst),
  .word_valid   (word_valid),
  .word_stall   (word_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .data_word    (data_word)
);

`default_nettype wire

[bench/tb.sv]
// testbench for sensor_safety_word_checker: directed frames from a table, then random
// frames over several register settings, each result checked against the table or an in-bench crc model
// depends on ssw_pkg and the checker rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 180;
  localparam int N_DIRECTED   = 25;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    status_t           st;
    logic [WORD_W-1:0] data;
  } frame_result_t;

  typedef struct {
    bit                reconfig;
    kind_t             kind;
    logic [WORD_W-1:0] value;
    bit                fix_crc;
    bit                typed;
    status_t           st;
    logic [WORD_W-1:0] data;
  } word_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  word_valid = 1'b0;
  logic                  word_stall;
  logic [KIND_W-1:0]     command = KIND_COMMAND;
  logic [WORD_W-1:0]     word_value = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [WORD_W-1:0]     data_word;

  // model copy of registers and frame state
  logic [CRC_W-1:0]  poly_r = POLY_RESET;
  logic [CRC_W-1:0]  seed_r = SEED_RESET;
  logic [MASK_W-1:0] sys_mask = SYSTEM_RESET;
  logic [MASK_W-1:0] ifc_mask = INTERFACE_RESET;
  logic [MASK_W-1:0] ang_mask = ANGLE_RESET;
  logic [CRC_W-1:0]  crc_acc = SEED_RESET;
  logic [WORD_W-1:0] last_data = '0;

  frame_result_t expected_results[$];
  int            mismatches = 0;
  int            words_sent = 0;
  bit            calm = 1'b0;

  word_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, KIND_SAFETY,  16'h0000, 1'b0, 1'b1, ST_SYSTEM,    16'h0000},
    '{1'b0, KIND_SAFETY,  16'h4000, 1'b0, 1'b1, ST_INTERFACE, 16'h0000},
    '{1'b0, KIND_SAFETY,  16'h6000, 1'b0, 1'b1, ST_ANGLE,     16'h0000},
    '{1'b0, KIND_SAFETY,  16'h7000, 1'b0, 1'b1, ST_OK,        16'h0000},
    '{1'b0, KIND_SAFETY,  16'h70FF, 1'b0, 1'b1, ST_CRC,       16'h0000},
    '{1'b0, KIND_UNUSED,  16'hFFFF, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_COMMAND, 16'h8021, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_SAFETY,  16'hFF00, 1'b1, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_COMMAND, 16'hFFFF, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_DATA,    16'h0000, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_DATA,    16'hFFFF, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_SAFETY,  16'h7000, 1'b1, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_SAFETY,  16'hF0AA, 1'b1, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_DATA,    16'h1234, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_SAFETY,  16'h7000, 1'b1, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_COMMAND, 16'hABCD, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_UNUSED,  16'h5555, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_DATA,    16'h00FF, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_SAFETY,  16'h7000, 1'b1, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_COMMAND, 16'h3C3C, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_DATA,    16'hC3C3, 1'b0, 1'b0, ST_OK,        16'h0000},
    // new polynomial and seed in the middle of an open frame
    '{1'b1, KIND_DATA,    16'h5A5A, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_SAFETY,  16'h7000, 1'b1, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_COMMAND, 16'hFFFF, 1'b0, 1'b0, ST_OK,        16'h0000},
    '{1'b0, KIND_SAFETY,  16'h8000, 1'b1, 1'b0, ST_OK,        16'h0000}
  };

  sensor_safety_word_checker dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .command      (command),
    .word_value   (word_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .data_word    (data_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  // bit-serial crc over a 16-bit word, msb first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] acc,
                                               input logic [WORD_W-1:0] w,
                                               input logic [CRC_W-1:0] poly);
    logic fb;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      fb  = acc[CRC_W-1] ^ w[i];
      acc = {acc[CRC_W-2:0], 1'b0} ^ (fb ? poly : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] lowest_one(input logic [7:0] b);
    return b & (~b + 8'h01);
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    logic [MASK_W-1:0] m;
    m = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      m |= 16'h0001 << $urandom_range(8, 15);
    end
    return m;
  endfunction

  function automatic void track_word(input kind_t k, input logic [WORD_W-1:0] v,
                                     input bit typed, input frame_result_t typed_res);
    frame_result_t r;
    case (k)
      KIND_COMMAND: begin
        crc_acc   = crc_feed(seed_r, v, poly_r);
        last_data = '0;
      end
      KIND_DATA: begin
        crc_acc   = crc_feed(crc_acc, v, poly_r);
        last_data = v;
      end
      KIND_SAFETY: begin
        if ((v & sys_mask) == '0) begin
          r.st = ST_SYSTEM;
        end else if ((v & ifc_mask) == '0) begin
          r.st = ST_INTERFACE;
        end else if ((v & ang_mask) == '0) begin
          r.st = ST_ANGLE;
        end else if (~crc_acc != v[7:0]) begin
          r.st = ST_CRC;
        end else begin
          r.st = ST_OK;
        end
        r.data = (r.st == ST_OK) ? last_data : '0;
        expected_results.push_back(typed ? typed_res : r);
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input frame_result_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected status %0d data %h, got status %0d data %h",
               what, want.st, want.data, status, data_word);
    end
  endfunction

  task automatic send_word(input kind_t k, input logic [WORD_W-1:0] v,
                           input bit typed, input frame_result_t typed_res);
    while (take_break()) begin
      word_valid <= 1'b0;
      @(posedge clk);
    end
    word_valid <= 1'b1;
    command    <= k;
    word_value <= v;
    @(posedge clk);
    while (word_stall) @(posedge clk);
    track_word(k, v, typed, typed_res);
    if (k != KIND_UNUSED) words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      REG_POLYNOMIAL: poly_r = d[CRC_W-1:0];
      REG_SEED:       seed_r = d[CRC_W-1:0];
      REG_SYSTEM:     sys_mask = d;
      REG_INTERFACE:  ifc_mask = d;
      REG_ANGLE:      ang_mask = d;
      default: ;
    endcase
  endtask

  // upper byte of the 8-bit registers carries junk that must be dropped
  task automatic set_config(input logic [CRC_W-1:0] poly, input logic [CRC_W-1:0] seed,
                            input logic [MASK_W-1:0] sys, input logic [MASK_W-1:0] ifc,
                            input logic [MASK_W-1:0] ang);
    write_reg(REG_POLYNOMIAL, {8'($urandom), poly});
    write_reg(REG_SEED, {8'($urandom), seed});
    write_reg(REG_SYSTEM, sys);
    write_reg(REG_INTERFACE, ifc);
    write_reg(REG_ANGLE, ang);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    word_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame();
    logic [WORD_W-1:0] w;
    int                n;
    n = $urandom_range(4);
    send_word(KIND_COMMAND, 16'($urandom), 1'b0, '0);
    repeat (n) send_word(KIND_DATA, 16'($urandom), 1'b0, '0);
    w = 16'($urandom);
    if ($urandom_range(99) < 85) begin
      w[15:8] |= lowest_one(sys_mask[15:8]) | lowest_one(ifc_mask[15:8])
               | lowest_one(ang_mask[15:8]);
      w[7:0] = ~crc_acc;
    end
    send_word(KIND_SAFETY, w, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    result_stall <= take_break();
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("no beat expected", '0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.st || data_word !== want.data) begin
          report_mismatch("field", want);
        end
      end
    end
  end

  initial begin
    logic [WORD_W-1:0] v;
    int                start;
    int                guard;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].reconfig) begin
        drain();
        set_config(8'h07, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end
      v = directed_rows[i].value;
      if (directed_rows[i].fix_crc) v[7:0] = ~crc_acc;
      send_word(directed_rows[i].kind, v, directed_rows[i].typed,
                '{directed_rows[i].st, directed_rows[i].data});
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_config(8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: set_config(8'hFF, 8'hFF, 16'h8000, 16'h0001, 16'h0100);
        2: set_config(POLY_RESET, SEED_RESET, 16'h0000, INTERFACE_RESET, ANGLE_RESET);
        default: set_config(8'($urandom), 8'($urandom), rand_mask(), rand_mask(), rand_mask());
      endcase
      calm = (p == 5);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        if ($urandom_range(99) < 80) begin
          send_frame();
        end else begin
          send_word(kind_t'($urandom_range(3)), 16'($urandom), 1'b0, '0);
        end
      end
    end
    calm = 1'b0;

    word_valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
